@@ rtl/period_frequency_meter_assert.svh @@
// Assertion macros for the period frequency meter checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef PERIOD_FREQUENCY_METER_ASSERT_SVH
`define PERIOD_FREQUENCY_METER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PFM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("period_frequency_meter: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define PFM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("period_frequency_meter: next-cycle check failed");

`endif

@@ rtl/pfm_pkg.sv @@
// Shared constants, register map and control types of the period frequency meter.
// No dependencies; every other file but the assertion macro header imports this package.
package pfm_pkg;

  localparam int CountWidth = 16;
  localparam int TpsWidth   = 16;
  localparam int FreqWidth  = 16;
  localparam int CodeWidth  = 8;

  localparam int PaddrWidth = 3;
  localparam int PdataWidth = 32;
  localparam int RegIdxWidth = PaddrWidth - 2;

  localparam logic [RegIdxWidth-1:0] RegTicksPerSecond = RegIdxWidth'(0);
  localparam logic [TpsWidth-1:0]    TpsReset          = TpsWidth'(10000);

  localparam int NumWidth = ((TpsWidth + 1 > CountWidth) ? TpsWidth + 1 : CountWidth) + 1;
  localparam int DenWidth = CountWidth + 1;
  localparam int StepWidth = $clog2(NumWidth + 1);

  localparam logic [FreqWidth-1:0] FreqDisplayMax = FreqWidth'(99);
  localparam logic [CodeWidth-1:0] CodeOverRange  = CodeWidth'(8'hEE);
  localparam logic [7:0]           BcdRecip       = 8'd205;
  localparam int                   BcdShift       = 11;
  localparam logic [6:0]           DigitBase      = 7'd10;

  typedef struct packed {
    logic start;
    logic take;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/pfm_if.sv @@
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on pfm_pkg for field widths.
interface pfm_in_if import pfm_pkg::*; ();
  logic valid;
  logic ready;
  logic level;

  modport source (output valid, output level, input ready);
  modport sink (input valid, input level, output ready);
endinterface

interface pfm_out_if import pfm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CodeWidth-1:0] display_code;
  logic [FreqWidth-1:0] frequency_hz;
  logic                 over_range;

  modport source (output valid, output display_code, output frequency_hz,
                  output over_range, input ready);
  modport sink (input valid, input display_code, input frequency_hz,
                input over_range, output ready);
endinterface

@@ rtl/period_frequency_meter.sv @@
// Period frequency meter top level: APB register, phase tracker, serial divider and
// result register. Depends on pfm_pkg, pfm_if, pfm_regs, pfm_phase and pfm_divider.
//
// Each input item is one sampled level. An item that completes no period is taken
// without delay and the next item may follow at once. The item that closes a period
// starts the bit-serial divider, which produces one quotient bit per cycle, NumWidth
// bits in all (18 with a 16-bit count); input is held off until the quotient moves into
// the output register, which waits while the previous result has not yet been taken.
// A result waiting in the output register does not by itself block input.
module period_frequency_meter import pfm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  pfm_in_if.sink                in_ch,
  pfm_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PaddrWidth-1:0] paddr,
  input  logic [PdataWidth-1:0] pwdata,
  output logic [PdataWidth-1:0] prdata,
  output logic                  pready
);

  logic [TpsWidth-1:0]   ticks_per_second;
  logic                  step;
  logic                  emit;
  logic [CountWidth-1:0] period;
  div_ctrl_t             div_ctrl;
  div_stat_t             div_stat;
  logic [NumWidth-1:0]   numer;
  logic [DenWidth-1:0]   denom;
  logic [NumWidth-1:0]   quotient;
  logic [FreqWidth-1:0]  freq;
  logic                  over;
  logic [6:0]            freq_low;
  logic [14:0]           recip_prod;
  logic [3:0]            tens;
  logic [6:0]            tens_x10;
  logic [6:0]            ones_wide;
  logic [CodeWidth-1:0]  code;
  logic                  load_out;

  pfm_regs u_regs (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .ticks_per_second (ticks_per_second)
  );

  assign in_ch.ready = !div_stat.busy && !div_stat.done;
  assign step        = in_ch.valid && in_ch.ready;

  pfm_phase u_phase (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .level  (in_ch.level),
    .emit   (emit),
    .period (period)
  );

  assign numer = NumWidth'({ticks_per_second, 1'b0}) + NumWidth'(period);
  assign denom = {period, 1'b0};

  assign load_out      = div_stat.done && (!out_ch.valid || out_ch.ready);
  assign div_ctrl.start = emit;
  assign div_ctrl.take  = load_out;

  pfm_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .numer    (numer),
    .denom    (denom),
    .stat     (div_stat),
    .quotient (quotient)
  );

  assign freq       = quotient[FreqWidth-1:0];
  assign over       = freq > FreqDisplayMax;
  assign freq_low   = freq[6:0];
  assign recip_prod = 15'(freq_low) * 15'(BcdRecip);
  assign tens       = recip_prod[BcdShift+3:BcdShift];
  assign tens_x10   = 7'({3'b000, tens} * DigitBase);
  assign ones_wide  = freq_low - tens_x10;
  assign code       = over ? CodeOverRange : {tens, ones_wide[3:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (load_out) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.display_code <= code;
      out_ch.frequency_hz <= freq;
      out_ch.over_range   <= over;
    end
  end

endmodule

@@ rtl/pfm_regs.sv @@
// APB-style configuration register file of the period frequency meter.
// Depends on pfm_pkg for the register map and widths.
module pfm_regs import pfm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PaddrWidth-1:0] paddr,
  input  logic [PdataWidth-1:0] pwdata,
  output logic [PdataWidth-1:0] prdata,
  output logic                  pready,
  output logic [TpsWidth-1:0]   ticks_per_second
);

  logic [RegIdxWidth-1:0] reg_idx;
  logic                   wr_en;

  assign reg_idx = paddr[PaddrWidth-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TpsReset;
    end else if (wr_en && reg_idx == RegTicksPerSecond) begin
      ticks_per_second <= pwdata[TpsWidth-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegTicksPerSecond: prdata = PdataWidth'(ticks_per_second);
      default:           prdata = '0;
    endcase
  end

endmodule

@@ rtl/pfm_phase.sv @@
// Four-phase edge tracker and saturating tick counter of the period frequency meter.
// Depends on pfm_pkg for the counter width.
module pfm_phase import pfm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  level,
  output logic                  emit,
  output logic [CountWidth-1:0] period
);

  localparam logic [1:0] PhSkipHigh  = 2'd0;
  localparam logic [1:0] PhWaitRise  = 2'd1;
  localparam logic [1:0] PhCountHigh = 2'd2;
  localparam logic [1:0] PhCountLow  = 2'd3;

  logic [1:0]            phase;
  logic [1:0]            phase_next;
  logic [CountWidth-1:0] tick_count;
  logic [CountWidth-1:0] tick_count_next;
  logic [CountWidth-1:0] bumped;

  assign bumped = (tick_count == '1) ? tick_count : tick_count + CountWidth'(1);
  assign period = (tick_count == '0) ? CountWidth'(1) : tick_count;

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    emit            = 1'b0;
    unique case (phase)
      PhSkipHigh: begin
        if (!level) phase_next = PhWaitRise;
      end
      PhWaitRise: begin
        if (level) begin
          tick_count_next = CountWidth'(1);
          phase_next      = PhCountHigh;
        end
      end
      PhCountHigh: begin
        tick_count_next = bumped;
        if (!level) phase_next = PhCountLow;
      end
      PhCountLow: begin
        if (!level) begin
          tick_count_next = bumped;
        end else begin
          emit            = step;
          tick_count_next = '0;
          phase_next      = PhSkipHigh;
        end
      end
      default: phase_next = PhSkipHigh;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PhSkipHigh;
      tick_count <= '0;
    end else if (step) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
    end
  end

endmodule

@@ rtl/pfm_divider.sv @@
// Bit-serial restoring divider: one quotient bit per cycle, result held until taken.
// Depends on pfm_pkg for operand widths and the control types.
module pfm_divider import pfm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  div_ctrl_t           ctrl,
  input  logic [NumWidth-1:0] numer,
  input  logic [DenWidth-1:0] denom,
  output div_stat_t           stat,
  output logic [NumWidth-1:0] quotient
);

  logic [NumWidth-1:0]  quo;
  logic [DenWidth-1:0]  rem;
  logic [DenWidth-1:0]  den;
  logic [StepWidth-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DenWidth:0]    trial;
  logic [DenWidth:0]    diff;
  logic                 fits;

  assign trial = {rem, quo[NumWidth-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (ctrl.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= StepWidth'(NumWidth);
    end else if (busy) begin
      cnt <= cnt - StepWidth'(1);
      if (cnt == StepWidth'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else if (ctrl.take) begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      quo <= numer;
      rem <= '0;
      den <= denom;
    end else if (busy) begin
      quo <= {quo[NumWidth-2:0], fits};
      rem <= fits ? diff[DenWidth-1:0] : trial[DenWidth-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

@@ rtl/pfm_checker.sv @@
// Port-level checker of the period frequency meter and its bind to the top level.
// Depends on pfm_pkg and the macros in period_frequency_meter_assert.svh.
`include "period_frequency_meter_assert.svh"

module pfm_checker import pfm_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [CodeWidth-1:0] display_code,
  input logic [FreqWidth-1:0] frequency_hz,
  input logic                 over_range
);

  `PFM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(display_code) && $stable(frequency_hz) && $stable(over_range))
  `PFM_ASSERT_NOW(a_range_flag, out_valid, over_range == (frequency_hz > FreqDisplayMax))
  `PFM_ASSERT_NOW(a_over_code, out_valid && over_range, display_code == CodeOverRange)
  `PFM_ASSERT_NOW(a_bcd_value, out_valid && !over_range,
    frequency_hz == FreqWidth'(display_code[7:4]) * FreqWidth'(10) + FreqWidth'(display_code[3:0]))

endmodule

bind period_frequency_meter pfm_checker u_pfm_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .display_code (out_ch.display_code),
  .frequency_hz (out_ch.frequency_hz),
  .over_range   (out_ch.over_range)
);
